// ----- rtl/oll_pkg.sv -----
`timescale 1ns / 1ps
// oll_pkg: shared constants, operation and status codes and the cell control struct
// used by oll_cell and ordered_list_engine; depends on nothing
package oll_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int DATA_W      = 8;
   localparam int POS_W       = 5;
   localparam int FUNC_W      = 2;
   localparam int CAP_W       = 6;
   localparam int OUT_CNT_W   = 6;
   localparam int STATUS_W    = 3;
   localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   // broadcast to every cell of the row
   typedef struct packed {
      logic              ins_go;
      logic              del_go;
      logic [CNT_W-1:0]  pos;
      logic [DATA_W-1:0] value;
      logic [CNT_W-1:0]  count;
   } cell_ctrl_type;

endpackage

// ----- rtl/oll_cell.sv -----
`timescale 1ns / 1ps
// oll_cell: one entry of the list row, with its compare and its shift mux
// depends on oll_pkg
module oll_cell (
   input  logic                        clock,
   input  oll_pkg::cell_ctrl_type      ctrl,
   input  logic [oll_pkg::IDX_W-1:0]   index,
   input  logic [oll_pkg::DATA_W-1:0]  left_data,
   input  logic [oll_pkg::DATA_W-1:0]  right_data,
   input  logic                        hit_below,
   output logic [oll_pkg::DATA_W-1:0]  data_out,
   output logic                        hit_upto
);
   import oll_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic [CNT_W-1:0]  my_idx;
   logic              own_hit;

   assign my_idx   = CNT_W'(index);
   // only entries below the count take part in the search
   assign own_hit  = (my_idx < ctrl.count) && (data_ff == ctrl.value);
   assign hit_upto = hit_below | own_hit;
   assign data_out = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins_go) begin
         if (my_idx == ctrl.pos) begin
            data_in = ctrl.value;
         end else if (my_idx > ctrl.pos) begin
            data_in = left_data;
         end
      end else if (ctrl.del_go && hit_upto) begin
         // at or above the first match: pull from the upper neighbour
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ----- rtl/ordered_list_engine.sv -----
`timescale 1ns / 1ps
// ordered_list_engine: bounded ordered byte list held in a row of oll_cell instances
// depends on oll_pkg and oll_cell
//
//   channel | dir | beat fields                                  | handshake
//   req     | in  | func, item_value, position                   | req_valid / req_ready
//   rsp     | out | item_out, found, entry_count, is_empty,      | rsp_valid / rsp_ready
//           |     | is_full, status                              |
//   csr     | in  | capacity                                     | csr_valid / csr_ready
//
// one request beat per cycle while responses are taken; the response is registered
// and shows in the cycle after the request is taken. the whole row of cells compares
// and shifts in the cycle the request is taken, so the first-match chain through the cells sets the cycle length.
// reset (synchronous) empties the list and sets capacity to 32; entry contents are not
// cleared since only entries below the count are ever looked at.
// a stalled response holds the next request back; req_ready is high whenever the
// response register is free or being emptied in the same cycle.
module ordered_list_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [oll_pkg::FUNC_W-1:0]      req_func,
   input  logic [oll_pkg::DATA_W-1:0]      req_item_value,
   input  logic [oll_pkg::POS_W-1:0]       req_position,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [oll_pkg::DATA_W-1:0]      rsp_item_out,
   output logic                            rsp_found,
   output logic [oll_pkg::OUT_CNT_W-1:0]   rsp_entry_count,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_full,
   output logic [oll_pkg::STATUS_W-1:0]    rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [oll_pkg::CAP_W-1:0]       csr_capacity
);
   import oll_pkg::*;

   // control state
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CAP_W-1:0]    cap_ff;
   logic                rsp_valid_ff;

   // response payload
   logic [DATA_W-1:0]   item_ff, item_in;
   logic                found_ff, found_in;
   logic [CNT_W-1:0]    rcount_ff;
   logic                empty_ff, empty_in;
   logic                full_ff, full_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                req_take;
   logic [CMP_W-1:0]    cap_wide;
   logic [CNT_W-1:0]    cap_eff;
   logic                list_full;
   logic [CNT_W-1:0]    pos_ext;
   logic                ins_go, del_go;
   logic                any_hit;
   cell_ctrl_type       cell_ctrl;

   logic [DATA_W-1:0]   cell_data [MAX_ENTRIES];
   logic                hit_upto  [MAX_ENTRIES];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // capacity clamped to 1..MAX_ENTRIES
   always_comb begin
      cap_wide = CMP_W'(cap_ff);
      if (cap_wide == '0) begin
         cap_eff = CNT_W'(1);
      end else if (cap_wide > CMP_W'(MAX_ENTRIES)) begin
         cap_eff = CNT_W'(MAX_ENTRIES);
      end else begin
         cap_eff = CNT_W'(cap_wide);
      end
   end

   assign list_full = count_ff >= cap_eff;
   assign pos_ext   = CNT_W'(req_position);
   assign any_hit   = hit_upto[MAX_ENTRIES-1];

   // request decode and result
   always_comb begin
      ins_go    = 1'b0;
      del_go    = 1'b0;
      item_in   = '0;
      found_in  = 1'b0;
      status_in = ST_OK;
      count_in  = count_ff;
      unique case (req_func)
         FUNC_READ: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (pos_ext >= count_ff) begin
               status_in = ST_RANGE;
            end else begin
               item_in = cell_data[IDX_W'(req_position)];
            end
         end
         FUNC_CHECK: begin
            found_in = any_hit;
            if (!any_hit) begin
               status_in = ST_NOTFOUND;
            end
         end
         FUNC_INSERT: begin
            if (list_full) begin
               status_in = ST_FULL;
            end else if (pos_ext > count_ff) begin
               status_in = ST_RANGE;
            end else begin
               ins_go   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_DELETE: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (!any_hit) begin
               status_in = ST_NOTFOUND;
            end else begin
               found_in = 1'b1;
               del_go   = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
      endcase
      empty_in = count_in == '0;
      full_in  = count_in >= cap_eff;
   end

   // the row only moves on a taken beat
   always_comb begin
      cell_ctrl.ins_go = ins_go && req_take;
      cell_ctrl.del_go = del_go && req_take;
      cell_ctrl.pos    = pos_ext;
      cell_ctrl.value  = req_item_value;
      cell_ctrl.count  = count_ff;
   end

   // row of cells; the match flag ripples upward, data shifts between neighbours
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic [DATA_W-1:0] left_d, right_d;
      logic              below;
      if (g == 0) begin : g_first
         assign left_d = '0;
         assign below  = 1'b0;
      end else begin : g_mid
         assign left_d = cell_data[g-1];
         assign below  = hit_upto[g-1];
      end
      if (g == MAX_ENTRIES - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_inner
         assign right_d = cell_data[g+1];
      end
      oll_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .index      (IDX_W'(g)),
         .left_data  (left_d),
         .right_data (right_d),
         .hit_below  (below),
         .data_out   (cell_data[g]),
         .hit_upto   (hit_upto[g])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity;
         end
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, loaded with each taken beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff   <= item_in;
         found_ff  <= found_in;
         rcount_ff <= count_in;
         empty_ff  <= empty_in;
         full_ff   <= full_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item_out    = item_ff;
   assign rsp_found       = found_ff;
   assign rsp_entry_count = OUT_CNT_W'(rcount_ff);
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;
   assign rsp_status      = status_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond the row length");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_func == FUNC_INSERT && !list_full && pos_ext <= count_ff)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("accepted insert did not grow the list");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rcount_ff == count_ff)
      else $error("response count differs from the held count");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> status_ff == ST_OK)
      else $error("found flagged with an error status");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (empty_ff == (rcount_ff == '0)))
      else $error("empty flag disagrees with count");

endmodule
